@@ src/assert_macros.svh @@
// Assertion macros shared by the shift-reduce recognizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property check, disabled while reset is high.
`define SRER_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property check that also holds during reset.
`define SRER_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRER_ASSERT(label, clk, rst, prop, msg)
`define SRER_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

@@ src/srer_pkg.sv @@
// Types, constants and helpers for the shift-reduce expression recognizer.
`timescale 1ns / 1ps
`default_nettype none
package srer_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   localparam logic [7:0] SYM_E     = 8'h45;
   localparam logic [7:0] SYM_D     = 8'h64;
   localparam logic [7:0] SYM_I     = 8'h69;
   localparam logic [7:0] SYM_PLUS  = 8'h2B;
   localparam logic [7:0] SYM_STAR  = 8'h2A;
   localparam logic [7:0] SYM_OPEN  = 8'h28;
   localparam logic [7:0] SYM_CLOSE = 8'h29;

   localparam logic [6:0] FIELD7_MAX = 7'd127;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_PUSH,
      OP_POP1,
      OP_POP2
   } stack_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_REDUCE
   } state_type;

   function automatic logic [6:0] sat7(input logic [CNT_W-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(FIELD7_MAX)) begin
         return FIELD7_MAX;
      end
      return wide[6:0];
   endfunction

endpackage
`default_nettype wire

@@ src/shift_reduce_expression_recognizer.sv @@
// Top level of the shift-reduce expression recognizer: control FSM and cell chain.
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_symbol, req_last
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_depth, rsp_reductions, rsp_overflow,
//          |           |                        | rsp_end_of_string, rsp_accepted
//
// A transaction is a push in the idle state (an overflow mark if the stack is full), then
// handle tests on the top two or three cells, each match shifting the whole chain once.
// Reset clears the FSM, stack count, overflow flag and output valid; stack cells are not reset.
// The result sits in an output register; a finished transaction waits in the reduce state
// while that register is still full, and req_ready is high only in the idle state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module shift_reduce_expression_recognizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_symbol,
   input  wire logic       req_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [6:0]      rsp_depth,
   output logic [6:0]      rsp_reductions,
   output logic            rsp_overflow,
   output logic            rsp_end_of_string,
   output logic            rsp_accepted
);

   localparam int DEPTH = srer_pkg::STACK_DEPTH;
   localparam int CW    = srer_pkg::CNT_W;

   srer_pkg::state_type    state_ff, state_in;
   srer_pkg::stack_op_type op;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] reds_ff, reds_in;
   logic          ovf_ff, ovf_in;
   logic          last_ff, last_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [6:0]    rsp_depth_ff, rsp_depth_in;
   logic [6:0]    rsp_reds_ff, rsp_reds_in;
   logic          rsp_ovf_ff, rsp_ovf_in;
   logic          rsp_eos_ff, rsp_eos_in;
   logic          rsp_acc_ff, rsp_acc_in;

   logic [7:0]    cell_val [DEPTH];
   logic [7:0]    prev_w   [DEPTH];
   logic [7:0]    next1_w  [DEPTH];
   logic [7:0]    next2_w  [DEPTH];

   logic          req_fire;
   logic          out_free;
   logic          match_id;
   logic          match3;
   logic          stack_full;

   // cell chain, index 0 is the top of stack
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_top
         assign prev_w[i]  = req_symbol;
         assign next1_w[i] = srer_pkg::SYM_E;
         assign next2_w[i] = srer_pkg::SYM_E;
      end else begin : g_body
         assign prev_w[i] = cell_val[i-1];
         if (i + 1 < DEPTH) begin : g_n1
            assign next1_w[i] = cell_val[i+1];
         end else begin : g_n1_end
            assign next1_w[i] = srer_pkg::SYM_E;
         end
         if (i + 2 < DEPTH) begin : g_n2
            assign next2_w[i] = cell_val[i+2];
         end else begin : g_n2_end
            assign next2_w[i] = srer_pkg::SYM_E;
         end
      end
      srer_cell u_cell (
         .clock      (clock),
         .op         (op),
         .from_prev  (prev_w[i]),
         .from_next1 (next1_w[i]),
         .from_next2 (next2_w[i]),
         .value      (cell_val[i])
      );
   end

   assign stack_full = (count_ff == CW'(DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;

   // handle tests on the top of stack, in priority order
   assign match_id = (count_ff >= CW'(2)) &&
                     (cell_val[1] == srer_pkg::SYM_I) && (cell_val[0] == srer_pkg::SYM_D);
   assign match3   = (count_ff >= CW'(3)) && (
                     ((cell_val[2] == srer_pkg::SYM_E) && (cell_val[1] == srer_pkg::SYM_PLUS) &&
                      (cell_val[0] == srer_pkg::SYM_E)) ||
                     ((cell_val[2] == srer_pkg::SYM_E) && (cell_val[1] == srer_pkg::SYM_STAR) &&
                      (cell_val[0] == srer_pkg::SYM_E)) ||
                     ((cell_val[2] == srer_pkg::SYM_OPEN) && (cell_val[1] == srer_pkg::SYM_E) &&
                      (cell_val[0] == srer_pkg::SYM_CLOSE)));

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srer_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = srer_pkg::ST_REDUCE;
            end
         end
         srer_pkg::ST_REDUCE: begin
            if (!match_id && !match3 && out_free) begin
               state_in = srer_pkg::ST_IDLE;
            end
         end
         default: state_in = srer_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      req_ready    = 1'b0;
      op           = srer_pkg::OP_HOLD;
      count_in     = count_ff;
      reds_in      = reds_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_depth_in = rsp_depth_ff;
      rsp_reds_in  = rsp_reds_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_eos_in   = rsp_eos_ff;
      rsp_acc_in   = rsp_acc_ff;
      unique case (state_ff)
         srer_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               reds_in = '0;
               last_in = req_last;
               if (stack_full) begin
                  ovf_in = 1'b1;
               end else begin
                  op       = srer_pkg::OP_PUSH;
                  count_in = count_ff + CW'(1);
               end
            end
         end
         srer_pkg::ST_REDUCE: begin
            priority if (match_id) begin
               op       = srer_pkg::OP_POP1;
               count_in = count_ff - CW'(1);
               reds_in  = reds_ff + CW'(1);
            end else if (match3) begin
               op       = srer_pkg::OP_POP2;
               count_in = count_ff - CW'(2);
               reds_in  = reds_ff + CW'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_depth_in = srer_pkg::sat7(count_ff);
               rsp_reds_in  = srer_pkg::sat7(reds_ff);
               rsp_ovf_in   = ovf_ff;
               rsp_eos_in   = last_ff;
               rsp_acc_in   = last_ff && !ovf_ff && (count_ff == CW'(1)) &&
                              (cell_val[0] == srer_pkg::SYM_E);
               if (last_ff) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end
            end else begin
               op = srer_pkg::OP_HOLD;
            end
         end
         default: begin
            op = srer_pkg::OP_HOLD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srer_pkg::ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      reds_ff      <= reds_in;
      last_ff      <= last_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_reds_ff  <= rsp_reds_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_eos_ff   <= rsp_eos_in;
      rsp_acc_ff   <= rsp_acc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_depth         = rsp_depth_ff;
   assign rsp_reductions    = rsp_reds_ff;
   assign rsp_overflow      = rsp_ovf_ff;
   assign rsp_end_of_string = rsp_eos_ff;
   assign rsp_accepted      = rsp_acc_ff;

   `SRER_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "stack count above depth")
   `SRER_ASSERT(a_reduce_shrinks, clock, reset, (state_ff == srer_pkg::ST_REDUCE) && (op != srer_pkg::OP_HOLD) |=> count_ff < $past(count_ff), "reduction did not shrink stack")
   `SRER_ASSERT(a_accept_at_end, clock, reset, rsp_valid_ff && rsp_acc_ff |-> rsp_eos_ff && !rsp_ovf_ff, "acceptance without clean end of string")
   `SRER_ASSERT(a_clear_at_end, clock, reset, (state_ff == srer_pkg::ST_REDUCE) && (state_in == srer_pkg::ST_IDLE) && last_ff |=> (count_ff == '0) && !ovf_ff, "stack not cleared after string end")
   `SRER_ASSERT_ALWAYS(a_ready_idle, clock, req_ready |-> (state_ff == srer_pkg::ST_IDLE), "ready outside idle state")

endmodule
`default_nettype wire

@@ src/srer_cell.sv @@
// One stack cell: holds a symbol and shifts toward or away from the top.
`timescale 1ns / 1ps
`default_nettype none
module srer_cell (
   input  wire logic                 clock,
   input  wire srer_pkg::stack_op_type op,
   input  wire logic [7:0]           from_prev,
   input  wire logic [7:0]           from_next1,
   input  wire logic [7:0]           from_next2,
   output logic [7:0]                value
);

   logic [7:0] value_ff;
   logic [7:0] value_in;

   always_comb begin
      unique case (op)
         srer_pkg::OP_HOLD: value_in = value_ff;
         srer_pkg::OP_PUSH: value_in = from_prev;
         srer_pkg::OP_POP1: value_in = from_next1;
         srer_pkg::OP_POP2: value_in = from_next2;
         default:           value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire
